[hw/rtl/scba_pkg.sv]
// Shared constants, types and helper functions of the size-class block allocator.
`default_nettype none
package scba_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int MIN_BLOCK  = 8;
  localparam int MAX_BLOCK  = 2048;
  localparam int NUM_PAGES  = 16;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int MIN_SHIFT  = $clog2(MIN_BLOCK);
  localparam int GPP_SHIFT  = PAGE_SHIFT - MIN_SHIFT;
  localparam int GPP        = 1 << GPP_SHIFT;
  localparam int PAGE_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int GRAN_W     = PAGE_W + GPP_SHIFT;
  localparam int CNT_W      = GPP_SHIFT + 1;
  localparam int RCNT_W     = $clog2(NUM_PAGES + 1);

  function automatic int calc_ncls();
    int n;
    n = 0;
    for (int i = 0; i < 16; i++) begin
      if (n == i && (MIN_BLOCK << i) <= MAX_BLOCK && (MIN_BLOCK << i) <= PAGE_BYTES)
        n = i + 1;
    end
    return n;
  endfunction

  localparam int NCLS    = calc_ncls();
  localparam int CLS_W   = $clog2(NCLS + 1);
  localparam int CIDX_W  = (NCLS > 1) ? $clog2(NCLS) : 1;

  typedef logic [GRAN_W-1:0]    gran_t;
  typedef logic [GRAN_W:0]      link_t;   // MSB set: no entry
  typedef logic [GRAN_W+1:0]    nxent_t;  // MSB: block sits on a free list
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CIDX_W-1:0]    cidx_t;
  typedef logic [CLS_W-1:0]     pcls_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [RCNT_W-1:0]    rcnt_t;
  typedef logic [GPP_SHIFT-1:0] gofs_t;

  localparam link_t LINK_NIL = link_t'({1'b1, {GRAN_W{1'b0}}});

  localparam logic [1:0] FN_ALLOC = 2'd0;
  localparam logic [1:0] FN_FREE  = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;
  localparam logic [1:0] FN_INIT  = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;
  localparam logic [1:0] ST_IGN = 2'd3;

  localparam logic REG_REGION_BASE  = 1'b0;
  localparam logic REG_PAGES_IN_USE = 1'b1;

  typedef struct packed {
    logic   nx_we;
    gran_t  nx_addr;
    nxent_t nx_data;
    logic   pv_we;
    gran_t  pv_addr;
    link_t  pv_data;
  } link_wr_t;

  // smallest class that holds size; NCLS when none does
  function automatic pcls_t size_class(input logic [11:0] size);
    int c;
    c = NCLS;
    for (int i = NCLS - 1; i >= 0; i--) begin
      if ((MIN_BLOCK << i) >= int'(size)) c = i;
    end
    return pcls_t'(c);
  endfunction

  function automatic logic [11:0] blk_bytes(input pcls_t pc);
    logic [11:0] b;
    b = '0;
    if (pc != '0 && int'(pc) <= NCLS) b = 12'(MIN_BLOCK << (int'(pc) - 1));
    return b;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/scba_link_mem.sv]
// Next and previous link memories of the block free lists, with registered reads.
`default_nettype none
module scba_link_mem (
  input  wire logic              clk,
  input  wire scba_pkg::gran_t   rd_addr,
  input  wire scba_pkg::link_wr_t wr,
  output scba_pkg::nxent_t       nx_rdata,
  output scba_pkg::link_t        pv_rdata
);

  localparam int DEPTH = scba_pkg::NUM_PAGES * scba_pkg::GPP;

  scba_pkg::nxent_t nx_mem [DEPTH];
  scba_pkg::link_t  pv_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.nx_we) nx_mem[wr.nx_addr] <= wr.nx_data;
    nx_rdata <= nx_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.pv_we) pv_mem[wr.pv_addr] <= wr.pv_data;
    pv_rdata <= pv_mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/size_class_block_allocator_core.sv]
// Init and query finish in idle; alloc from a list unlinks the head block; a page split appends
// each page block to the class tail, then unlinks the first; free checks the on-list mark and
// ignores a double free, else pushes at the list head; a page release unlinks each page block.
// One command at a time; busy drops in the cycle the result strobe is shown.
// Link memories have one read port with a registered read; each list unlink steps through S_RM_RD, S_RM_W1, S_RM_W2.
// Reset (synchronous, rst_n low): lists empty, page records clear, page deque empty.
// Results are shown for one cycle on out_valid; the receiver cannot stall.
`default_nettype none
module size_class_block_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [11:0] in_request_size,
  input  wire logic [31:0] in_block_address,
  input  wire logic        in_page_ok,
  output logic             out_valid,
  output logic [31:0]      out_result_address,
  output logic [11:0]      out_block_bytes,
  output logic [1:0]       out_status,
  output logic             out_page_released,
  output logic [31:0]      out_released_page_address,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);

  localparam int NCLS      = scba_pkg::NCLS;
  localparam int NUM_PAGES = scba_pkg::NUM_PAGES;
  localparam int GRAN_W    = scba_pkg::GRAN_W;
  localparam int GPP_SHIFT = scba_pkg::GPP_SHIFT;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SPLIT     = 4'd1;
  localparam logic [3:0] S_SPLIT_END = 4'd2;
  localparam logic [3:0] S_RM_RD     = 4'd3;
  localparam logic [3:0] S_RM_W1     = 4'd4;
  localparam logic [3:0] S_RM_W2     = 4'd5;
  localparam logic [3:0] S_FR_RD     = 4'd6;
  localparam logic [3:0] S_FR_CHK    = 4'd7;
  localparam logic [3:0] S_FR_B      = 4'd8;
  localparam logic [3:0] S_REL_END   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [31:0] base_r;
  logic [4:0]  pages_r;

  scba_pkg::gran_t  g_r, g_nxt;
  scba_pkg::cidx_t  cls_r, cls_nxt;
  scba_pkg::page_t  page_r, page_nxt;
  scba_pkg::gofs_t  k_r, k_nxt;
  scba_pkg::link_t  prev_r, prev_nxt;
  scba_pkg::link_t  h_r, h_nxt;
  logic             rel_mode_r, rel_mode_nxt;

  logic [31:0] res_addr_r, res_addr_nxt;
  logic [11:0] bytes_r, bytes_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        rel_r, rel_nxt;
  logic [31:0] rel_addr_r, rel_addr_nxt;
  logic        out_valid_r, out_valid_nxt;

  scba_pkg::link_t head_r [NCLS];
  scba_pkg::link_t head_nxt [NCLS];
  scba_pkg::link_t tail_r [NCLS];
  scba_pkg::link_t tail_nxt [NCLS];
  scba_pkg::pcls_t pcls_r [NUM_PAGES];
  scba_pkg::pcls_t pcls_nxt [NUM_PAGES];
  scba_pkg::cnt_t  pcnt_r [NUM_PAGES];
  scba_pkg::cnt_t  pcnt_nxt [NUM_PAGES];
  scba_pkg::page_t ring_r [NUM_PAGES];
  scba_pkg::page_t ring_nxt [NUM_PAGES];
  scba_pkg::page_t rhead_r, rhead_nxt;
  scba_pkg::rcnt_t rcount_r, rcount_nxt;

  scba_pkg::link_wr_t lwr;
  scba_pkg::nxent_t   nx_rdata;
  scba_pkg::link_t    pv_rdata;

  scba_link_mem u_link (
    .clk      (clk),
    .rd_addr  (g_r),
    .wr       (lwr),
    .nx_rdata (nx_rdata),
    .pv_rdata (pv_rdata)
  );

  // decode of the incoming command
  logic [31:0]      off;
  scba_pkg::rcnt_t  live;
  logic             in_range;
  scba_pkg::page_t  p_in;
  scba_pkg::pcls_t  pc_in;
  scba_pkg::pcls_t  c_in;
  scba_pkg::cidx_t  fcls;
  scba_pkg::gofs_t  gofs;
  scba_pkg::cidx_t  bk;
  logic             bfound;
  scba_pkg::page_t  sp;
  scba_pkg::gofs_t  kstep;
  logic             k_last;
  scba_pkg::page_t  g_page;
  scba_pkg::cnt_t   full_cnt;
  int               push_idx;

  assign off      = in_block_address - base_r;
  assign live     = scba_pkg::rcnt_t'((int'(pages_r) > NUM_PAGES) ? NUM_PAGES : int'(pages_r));
  assign in_range = (off >> scba_pkg::PAGE_SHIFT) < 32'(live);
  assign p_in     = off[scba_pkg::PAGE_SHIFT +: scba_pkg::PAGE_W];
  assign pc_in    = pcls_r[p_in];
  assign c_in     = scba_pkg::size_class(in_request_size);
  assign fcls     = scba_pkg::cidx_t'(pc_in - scba_pkg::pcls_t'(1));
  assign gofs     = off[scba_pkg::PAGE_SHIFT-1:scba_pkg::MIN_SHIFT] &
                    ({GPP_SHIFT{1'b1}} << fcls);
  assign sp       = ring_r[rhead_r];
  assign kstep    = scba_pkg::gofs_t'(1) << cls_r;
  assign k_last   = &(k_r | ~({GPP_SHIFT{1'b1}} << cls_r));
  assign g_page   = g_r[GRAN_W-1:GPP_SHIFT];
  assign full_cnt = scba_pkg::cnt_t'(scba_pkg::GPP) >> cls_r;
  assign push_idx = (int'(rhead_r) + int'(rcount_r) >= NUM_PAGES) ?
                    int'(rhead_r) + int'(rcount_r) - NUM_PAGES :
                    int'(rhead_r) + int'(rcount_r);

  // first larger class with a free block
  always_comb begin
    bk = '0;
    bfound = 1'b0;
    for (int k = 0; k < NCLS; k++) begin
      if (!bfound && k > int'(c_in) && !head_r[k][GRAN_W]) begin
        bk = scba_pkg::cidx_t'(k);
        bfound = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    g_nxt         = g_r;
    cls_nxt       = cls_r;
    page_nxt      = page_r;
    k_nxt         = k_r;
    prev_nxt      = prev_r;
    h_nxt         = h_r;
    rel_mode_nxt  = rel_mode_r;
    res_addr_nxt  = res_addr_r;
    bytes_nxt     = bytes_r;
    status_nxt    = status_r;
    rel_nxt       = rel_r;
    rel_addr_nxt  = rel_addr_r;
    out_valid_nxt = 1'b0;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    pcls_nxt      = pcls_r;
    pcnt_nxt      = pcnt_r;
    ring_nxt      = ring_r;
    rhead_nxt     = rhead_r;
    rcount_nxt    = rcount_r;
    lwr           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_addr_nxt = '0;
          bytes_nxt    = '0;
          status_nxt   = scba_pkg::ST_OK;
          rel_nxt      = 1'b0;
          rel_addr_nxt = '0;
          rel_mode_nxt = 1'b0;
          unique case (in_func)
            scba_pkg::FN_INIT: begin
              for (int i = 0; i < NCLS; i++) begin
                head_nxt[i] = scba_pkg::LINK_NIL;
                tail_nxt[i] = scba_pkg::LINK_NIL;
              end
              for (int i = 0; i < NUM_PAGES; i++) begin
                pcls_nxt[i] = '0;
                pcnt_nxt[i] = '0;
                ring_nxt[i] = scba_pkg::page_t'(i);
              end
              rhead_nxt     = '0;
              rcount_nxt    = live;
              out_valid_nxt = 1'b1;
            end
            scba_pkg::FN_QUERY: begin
              if (!in_range) status_nxt = scba_pkg::ST_BAD;
              else bytes_nxt = scba_pkg::blk_bytes(pc_in);
              out_valid_nxt = 1'b1;
            end
            scba_pkg::FN_ALLOC: begin
              if (in_request_size == '0 || int'(c_in) >= NCLS) begin
                status_nxt    = scba_pkg::ST_BAD;
                out_valid_nxt = 1'b1;
              end else if (!head_r[c_in[scba_pkg::CIDX_W-1:0]][GRAN_W]) begin
                cls_nxt   = c_in[scba_pkg::CIDX_W-1:0];
                g_nxt     = head_r[c_in[scba_pkg::CIDX_W-1:0]][GRAN_W-1:0];
                state_nxt = S_RM_RD;
              end else if (rcount_r != '0) begin
                if (!in_page_ok) begin
                  status_nxt    = scba_pkg::ST_OOM;
                  out_valid_nxt = 1'b1;
                end else begin
                  // take the page at the deque head and carve it
                  rhead_nxt = (int'(rhead_r) == NUM_PAGES - 1) ? '0 :
                              rhead_r + scba_pkg::page_t'(1);
                  rcount_nxt   = rcount_r - scba_pkg::rcnt_t'(1);
                  pcls_nxt[sp] = c_in + scba_pkg::pcls_t'(1);
                  pcnt_nxt[sp] = scba_pkg::cnt_t'(scba_pkg::GPP) >> c_in;
                  page_nxt     = sp;
                  cls_nxt      = c_in[scba_pkg::CIDX_W-1:0];
                  k_nxt        = '0;
                  prev_nxt     = scba_pkg::LINK_NIL;
                  state_nxt    = S_SPLIT;
                end
              end else if (bfound) begin
                cls_nxt   = bk;
                g_nxt     = head_r[bk][GRAN_W-1:0];
                state_nxt = S_RM_RD;
              end else begin
                status_nxt    = scba_pkg::ST_OOM;
                out_valid_nxt = 1'b1;
              end
            end
            scba_pkg::FN_FREE: begin
              if (!in_range || pc_in == '0 || int'(pc_in) > NCLS) begin
                status_nxt    = scba_pkg::ST_IGN;
                out_valid_nxt = 1'b1;
              end else begin
                g_nxt     = {p_in, gofs};
                cls_nxt   = fcls;
                page_nxt  = p_in;
                state_nxt = S_FR_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_SPLIT: begin
        // append block k to the class tail
        lwr.pv_we   = 1'b1;
        lwr.pv_addr = {page_r, k_r};
        lwr.pv_data = prev_r;
        if (prev_r[GRAN_W]) begin
          head_nxt[cls_r] = {1'b0, page_r, k_r};
        end else begin
          lwr.nx_we   = 1'b1;
          lwr.nx_addr = prev_r[GRAN_W-1:0];
          lwr.nx_data = {1'b1, 1'b0, page_r, k_r};
        end
        tail_nxt[cls_r] = {1'b0, page_r, k_r};
        prev_nxt        = {1'b0, page_r, k_r};
        if (k_last) state_nxt = S_SPLIT_END;
        else k_nxt = k_r + kstep;
      end

      S_SPLIT_END: begin
        lwr.nx_we   = 1'b1;
        lwr.nx_addr = prev_r[GRAN_W-1:0];
        lwr.nx_data = {1'b1, scba_pkg::LINK_NIL};
        g_nxt       = {page_r, {GPP_SHIFT{1'b0}}};
        state_nxt   = S_RM_RD;
      end

      S_RM_RD: state_nxt = S_RM_W1;

      S_RM_W1: begin
        // unlink g: bridge its neighbours
        if (pv_rdata[GRAN_W]) begin
          head_nxt[cls_r] = nx_rdata[GRAN_W:0];
        end else begin
          lwr.nx_we   = 1'b1;
          lwr.nx_addr = pv_rdata[GRAN_W-1:0];
          lwr.nx_data = {1'b1, nx_rdata[GRAN_W:0]};
        end
        if (nx_rdata[GRAN_W]) begin
          tail_nxt[cls_r] = pv_rdata;
        end else begin
          lwr.pv_we   = 1'b1;
          lwr.pv_addr = nx_rdata[GRAN_W-1:0];
          lwr.pv_data = pv_rdata;
        end
        state_nxt = S_RM_W2;
      end

      S_RM_W2: begin
        // drop the on-list mark of g
        lwr.nx_we   = 1'b1;
        lwr.nx_addr = g_r;
        lwr.nx_data = {1'b0, scba_pkg::LINK_NIL};
        if (rel_mode_r) begin
          if (k_last) begin
            state_nxt = S_REL_END;
          end else begin
            k_nxt     = k_r + kstep;
            g_nxt     = {page_r, k_r + kstep};
            state_nxt = S_RM_RD;
          end
        end else begin
          if (pcnt_r[g_page] != '0) pcnt_nxt[g_page] = pcnt_r[g_page] - scba_pkg::cnt_t'(1);
          res_addr_nxt  = base_r + (32'(g_r) << scba_pkg::MIN_SHIFT);
          bytes_nxt     = scba_pkg::blk_bytes(pcls_r[g_page]);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_FR_RD: state_nxt = S_FR_CHK;

      S_FR_CHK: begin
        if (nx_rdata[GRAN_W+1]) begin
          status_nxt    = scba_pkg::ST_IGN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          lwr.nx_we   = 1'b1;
          lwr.nx_addr = g_r;
          lwr.nx_data = {1'b1, head_r[cls_r]};
          lwr.pv_we   = 1'b1;
          lwr.pv_addr = g_r;
          lwr.pv_data = scba_pkg::LINK_NIL;
          h_nxt       = head_r[cls_r];
          head_nxt[cls_r] = {1'b0, g_r};
          if (head_r[cls_r][GRAN_W]) tail_nxt[cls_r] = {1'b0, g_r};
          pcnt_nxt[page_r] = pcnt_r[page_r] + scba_pkg::cnt_t'(1);
          state_nxt = S_FR_B;
        end
      end

      S_FR_B: begin
        if (!h_r[GRAN_W]) begin
          lwr.pv_we   = 1'b1;
          lwr.pv_addr = h_r[GRAN_W-1:0];
          lwr.pv_data = {1'b0, g_r};
        end
        if (pcnt_r[page_r] >= full_cnt) begin
          // page wholly free: unlink each of its blocks
          rel_mode_nxt = 1'b1;
          k_nxt        = '0;
          g_nxt        = {page_r, {GPP_SHIFT{1'b0}}};
          state_nxt    = S_RM_RD;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      S_REL_END: begin
        pcls_nxt[page_r] = '0;
        pcnt_nxt[page_r] = '0;
        if (int'(rcount_r) < NUM_PAGES) begin
          ring_nxt[push_idx[scba_pkg::PAGE_W-1:0]] = page_r;
          rcount_nxt = rcount_r + scba_pkg::rcnt_t'(1);
        end
        rel_nxt       = 1'b1;
        rel_addr_nxt  = base_r + (32'(page_r) << scba_pkg::PAGE_SHIFT);
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      pages_r     <= '0;
      rhead_r     <= '0;
      rcount_r    <= '0;
      for (int i = 0; i < NCLS; i++) begin
        head_r[i] <= scba_pkg::LINK_NIL;
        tail_r[i] <= scba_pkg::LINK_NIL;
      end
      for (int i = 0; i < NUM_PAGES; i++) begin
        pcls_r[i] <= '0;
        pcnt_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rhead_r     <= rhead_nxt;
      rcount_r    <= rcount_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      pcls_r      <= pcls_nxt;
      pcnt_r      <= pcnt_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          scba_pkg::REG_REGION_BASE:  base_r  <= cfg_wdata;
          scba_pkg::REG_PAGES_IN_USE: pages_r <= cfg_wdata[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    g_r        <= g_nxt;
    cls_r      <= cls_nxt;
    page_r     <= page_nxt;
    k_r        <= k_nxt;
    prev_r     <= prev_nxt;
    h_r        <= h_nxt;
    rel_mode_r <= rel_mode_nxt;
    res_addr_r <= res_addr_nxt;
    bytes_r    <= bytes_nxt;
    status_r   <= status_nxt;
    rel_r      <= rel_nxt;
    rel_addr_r <= rel_addr_nxt;
    ring_r     <= ring_nxt;
  end

  assign busy                      = (state_r != S_IDLE);
  assign cfg_ready                 = 1'b1;
  assign out_valid                 = out_valid_r;
  assign out_result_address        = res_addr_r;
  assign out_block_bytes           = bytes_r;
  assign out_status                = status_r;
  assign out_page_released         = rel_r;
  assign out_released_page_address = rel_addr_r;

endmodule
`default_nettype wire
